// ----- hw/rtl/raster_palette_cycler_defines.svh -----
// Assertion macros shared by the raster palette cycler RTL
`ifndef RASTER_PALETTE_CYCLER_DEFINES_SVH
`define RASTER_PALETTE_CYCLER_DEFINES_SVH

// Condition that must hold at every clock edge out of reset
`define RPC_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequence that must hold in the cycle after the antecedent
`define RPC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/rpc_pkg.sv -----
// Types, codes and constant tables of the raster palette cycler
package rpc_pkg;

    // Result action codes
    typedef enum logic [1:0] {
        ACT_PALETTE    = 2'd0,
        ACT_KEY_SCAN   = 2'd1,
        ACT_CLOCK_TICK = 2'd2
    } action_t;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_RESET_LINE      = 3'd0,
        REG_TEXT_START_LINE = 3'd1,
        REG_TEXT_END_LINE   = 3'd2,
        REG_PULSE_SPEED     = 3'd3,
        REG_PULSE_MAX       = 3'd4
    } reg_idx_t;

    // Round-robin slot codes
    localparam logic [2:0] SLOT_KEY_SCAN   = 3'd1;
    localparam logic [2:0] SLOT_CLOCK_TICK = 3'd2;
    localparam logic [2:0] SLOT_PHASE      = 3'd3;
    localparam logic [2:0] SLOT_PULSE      = 3'd4;

    // Pens
    localparam logic [1:0] PEN_BACKGROUND = 2'd0;
    localparam logic [1:0] PEN_STAR       = 2'd1;
    localparam logic [1:0] PEN_TEXT       = 2'd2;

    // Fixed colours, G<<8 | R<<4 | B
    localparam logic [11:0] COL_WHITE = 12'hFFF;
    localparam logic [11:0] COL_BASE  = 12'h324;

    typedef struct packed {
        logic [7:0] reset_line;
        logic [7:0] text_start_line;
        logic [7:0] text_end_line;
        logic [7:0] pulse_speed;
        logic [3:0] pulse_max;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        reset_line:      8'd8,
        text_start_line: 8'd120,
        text_end_line:   8'd148,
        pulse_speed:     8'd4,
        pulse_max:       4'd15
    };

    typedef struct packed {
        logic [2:0] slot;
        logic [4:0] phase;
        logic [7:0] pulse_tick;
        logic [3:0] pulse_level;
        logic       pulse_down;
    } state_t;

    typedef struct packed {
        action_t     action;
        logic [1:0]  pen;
        logic [11:0] colour;
        logic        last;
    } result_t;

    // Colour band table; entries past the defined ones read as black
    function automatic logic [11:0] band_colour(input logic [4:0] idx);
        logic [11:0] c;
        case (idx)
            5'd0:    c = 12'h0E6;
            5'd1:    c = 12'h0F4;
            5'd2:    c = 12'h0F2;
            5'd3:    c = 12'h1F0;
            5'd4:    c = 12'h3F0;
            5'd5:    c = 12'h5F0;
            5'd6:    c = 12'h7F0;
            5'd7:    c = 12'h9F0;
            5'd8:    c = 12'hBF0;
            5'd9:    c = 12'hEE0;
            5'd10:   c = 12'hEB0;
            5'd11:   c = 12'hE80;
            5'd12:   c = 12'hD42;
            5'd13:   c = 12'hC23;
            5'd14:   c = 12'hB24;
            5'd15:   c = 12'h926;
            5'd16:   c = 12'h738;
            5'd17:   c = 12'h558;
            5'd18:   c = 12'h377;
            5'd19:   c = 12'h296;
            5'd20:   c = 12'h1C6;
            default: c = 12'h000;
        endcase
        return c;
    endfunction

endpackage

// ----- hw/rtl/raster_palette_cycler.sv -----
// Top level of the raster palette cycler: registers, result buffer and ports
//
//  Channel   Direction  Moves
//  cfg       in         one register write (index, data)
//  s_axis    in         one raster line event
//  m_axis    out        one result: palette write or service request
//
//  An event is registered on acceptance and evaluated from the input register; its
//  results are registered in the result buffer on commit and drive m_axis from
//  there. Events with zero or one result flow at one per cycle while m_axis is
//  not stalled; the reset line's pair of palette writes leaves one by one over the
//  single m_axis result port. A stalled m_axis holds the result buffer; one more
//  event then waits in the input register, after which input stops. Reset is
//  asynchronous and restores registers and state at once; there is no clearing pass.
`include "raster_palette_cycler_defines.svh"

module raster_palette_cycler #(
    parameter int COLOUR_COUNT = 21,
    parameter int SLOT_COUNT   = 6
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] line
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [1:0] action, [3:2] pen, [15:4] colour
    output logic        m_axis_tlast
);

    rpc_pkg::cfg_t    cfg_reg;
    rpc_pkg::state_t  st_reg;
    rpc_pkg::state_t  st_next;
    logic             in_valid_reg;
    logic [7:0]       in_line_reg;
    rpc_pkg::result_t q0_reg;
    rpc_pkg::result_t q1_reg;
    logic [1:0]       cnt_reg;
    rpc_pkg::result_t res0;
    rpc_pkg::result_t res1;
    logic [1:0]       res_cnt;
    logic             pop;
    logic             commit;
    logic             phase_in_range;
    logic             slot_in_range;

    // Configuration writes are always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= rpc_pkg::CFG_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                rpc_pkg::REG_RESET_LINE:      cfg_reg.reset_line      <= cfg_data;
                rpc_pkg::REG_TEXT_START_LINE: cfg_reg.text_start_line <= cfg_data;
                rpc_pkg::REG_TEXT_END_LINE:   cfg_reg.text_end_line   <= cfg_data;
                rpc_pkg::REG_PULSE_SPEED:     cfg_reg.pulse_speed     <= cfg_data;
                rpc_pkg::REG_PULSE_MAX:       cfg_reg.pulse_max       <= cfg_data[3:0];
                default:
                begin
                end
            endcase
        end
    end

    // Evaluate the registered event
    rpc_eval #(
        .COLOUR_COUNT (COLOUR_COUNT),
        .SLOT_COUNT   (SLOT_COUNT)
    ) u_eval (
        .line    (in_line_reg),
        .cfg     (cfg_reg),
        .st      (st_reg),
        .res0    (res0),
        .res1    (res1),
        .res_cnt (res_cnt),
        .st_next (st_next)
    );

    // Commit an event once the buffer will be empty after this cycle's transfer
    assign pop           = m_axis_tvalid && m_axis_tready;
    assign commit        = in_valid_reg && ((cnt_reg == 2'd0) || (cnt_reg == 2'd1 && pop));
    assign s_axis_tready = !in_valid_reg || commit;

    // Hold the incoming event
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_line_reg <= s_axis_tdata;
        end
    end

    // Advance the round robin and pulse state on commit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= '0;
        end
        else if (commit)
        begin
            st_reg <= st_next;
        end
    end

    // Load results on commit, shift forward on each output transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else if (commit)
        begin
            cnt_reg <= res_cnt;
        end
        else if (pop)
        begin
            cnt_reg <= 2'(cnt_reg - 2'd1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            q0_reg <= res0;
            q1_reg <= res1;
        end
        else if (pop)
        begin
            q0_reg <= q1_reg;
        end
    end

    // Drive the result port from the buffer head
    assign m_axis_tvalid = (cnt_reg != 2'd0);
    assign m_axis_tdata  = {q0_reg.colour, q0_reg.pen, q0_reg.action};
    assign m_axis_tlast  = q0_reg.last;

    // Checks
    assign phase_in_range = (6'(st_reg.phase) < 6'(COLOUR_COUNT));
    assign slot_in_range  = (4'(st_reg.slot) < 4'(SLOT_COUNT));

    `RPC_ASSERT_ALWAYS(a_phase_range, phase_in_range, "colour phase out of range")
    `RPC_ASSERT_ALWAYS(a_slot_range, slot_in_range, "round robin slot out of range")
    `RPC_ASSERT_NEXT(a_pair_follows, pop && !m_axis_tlast, m_axis_tvalid && m_axis_tlast, "pair split")

endmodule

// ----- hw/rtl/rpc_eval.sv -----
// Per-event evaluation: results and next state for one raster line
module rpc_eval #(
    parameter int COLOUR_COUNT = 21,
    parameter int SLOT_COUNT   = 6
) (
    input  logic [7:0]       line,
    input  rpc_pkg::cfg_t    cfg,
    input  rpc_pkg::state_t  st,
    output rpc_pkg::result_t res0,
    output rpc_pkg::result_t res1,
    output logic [1:0]       res_cnt,
    output rpc_pkg::state_t  st_next
);

    localparam int RW = 13;

    logic [5:0]    band;
    logic [RW-1:0] idx_raw;
    logic [4:0]    rom_idx;
    logic [7:0]    tick_inc;
    logic [7:0]    level_step;
    logic [3:0]    slot_inc;
    logic [5:0]    phase_inc;

    // Reduce (band + count - phase) modulo the colour count, one bit a step
    always_comb
    begin
        logic [RW-1:0] x;
        band = 6'((line - cfg.text_start_line) >> 2);
        x = RW'(band) + RW'(COLOUR_COUNT) - RW'(st.phase);
        for (int k = 6; k >= 0; k--)
        begin
            if (x >= (RW'(COLOUR_COUNT) << k))
            begin
                x = x - (RW'(COLOUR_COUNT) << k);
            end
        end
        idx_raw = x;
    end

    assign rom_idx    = idx_raw[4:0];
    assign tick_inc   = st.pulse_tick + 8'd1;
    assign level_step = 8'(st.pulse_level) + (st.pulse_down ? 8'd255 : 8'd1);
    assign slot_inc   = 4'(st.slot) + 4'd1;
    assign phase_inc  = 6'(st.phase) + 6'd1;

    // Decode the line and form results and state update
    always_comb
    begin
        res0    = '0;
        res1    = '0;
        res_cnt = 2'd0;
        st_next = st;
        if (line == 8'd0)
        begin
            case (st.slot)
                rpc_pkg::SLOT_KEY_SCAN:
                begin
                    res0.action = rpc_pkg::ACT_KEY_SCAN;
                    res0.last   = 1'b1;
                    res_cnt     = 2'd1;
                end
                rpc_pkg::SLOT_CLOCK_TICK:
                begin
                    res0.action = rpc_pkg::ACT_CLOCK_TICK;
                    res0.last   = 1'b1;
                    res_cnt     = 2'd1;
                end
                rpc_pkg::SLOT_PHASE:
                begin
                    st_next.phase = (phase_inc >= 6'(COLOUR_COUNT)) ? 5'd0 : phase_inc[4:0];
                end
                rpc_pkg::SLOT_PULSE:
                begin
                    if (tick_inc < cfg.pulse_speed)
                    begin
                        st_next.pulse_tick = tick_inc;
                    end
                    else
                    begin
                        st_next.pulse_tick = 8'd0;
                        if (level_step >= 8'(cfg.pulse_max))
                        begin
                            st_next.pulse_level = cfg.pulse_max;
                            st_next.pulse_down  = 1'b1;
                        end
                        else
                        begin
                            st_next.pulse_level = level_step[3:0];
                            if (level_step == 8'd0)
                            begin
                                st_next.pulse_down = 1'b0;
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
            st_next.slot = (slot_inc >= 4'(SLOT_COUNT)) ? 3'd0 : slot_inc[2:0];
        end
        else if (line == cfg.reset_line)
        begin
            res0.action = rpc_pkg::ACT_PALETTE;
            res0.pen    = rpc_pkg::PEN_BACKGROUND;
            res0.colour = rpc_pkg::COL_WHITE;
            res0.last   = 1'b0;
            res1.action = rpc_pkg::ACT_PALETTE;
            res1.pen    = rpc_pkg::PEN_STAR;
            res1.colour = {4'd0, st.pulse_level, st.pulse_level};
            res1.last   = 1'b1;
            res_cnt     = 2'd2;
        end
        else if (line == cfg.text_end_line)
        begin
            res0.action = rpc_pkg::ACT_PALETTE;
            res0.pen    = rpc_pkg::PEN_TEXT;
            res0.colour = rpc_pkg::COL_BASE;
            res0.last   = 1'b1;
            res_cnt     = 2'd1;
        end
        else if (line >= cfg.text_start_line && line <= cfg.text_end_line)
        begin
            res0.action = rpc_pkg::ACT_PALETTE;
            res0.pen    = rpc_pkg::PEN_TEXT;
            res0.colour = rpc_pkg::band_colour(rom_idx);
            res0.last   = 1'b1;
            res_cnt     = 2'd1;
        end
    end

endmodule

// ----- test/raster_palette_cycler_tb.sv -----
// Self-checking testbench for the raster palette cycler: line events in, palette writes and service requests out
module raster_palette_cycler_tb;

    localparam int COLOUR_COUNT  = 21;
    localparam int SLOT_COUNT    = 6;
    localparam int PHASE_ITEMS   = 150;
    localparam int LONG_HOLD     = 300;
    localparam int SETTLE_LIMIT  = 2000;
    localparam int DRAIN_CYCLES  = 10;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int MAX_PRINTED   = 50;

    localparam logic [1:0]  NO_PEN    = 2'd0;
    localparam logic [11:0] NO_COLOUR = 12'h000;

    // Colour band table, entry 0 in the lowest bits
    localparam logic [COLOUR_COUNT*12-1:0] BAND_ROM = {
        12'h1C6, 12'h296, 12'h377, 12'h558, 12'h738, 12'h926, 12'hB24,
        12'hC23, 12'hD42, 12'hE80, 12'hEB0, 12'hEE0, 12'hBF0, 12'h9F0,
        12'h7F0, 12'h5F0, 12'h3F0, 12'h1F0, 12'h0F2, 12'h0F4, 12'h0E6
    };

    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_RHYTHM} rx_mode_t;

    typedef struct packed {
        logic [7:0]       line;
        logic             typed;
        logic [1:0]       count;
        rpc_pkg::result_t first;
        rpc_pkg::result_t second;
    } line_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = rpc_pkg::REG_RESET_LINE;
    logic [7:0]  cfg_data = 8'd0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;   // [7:0] line
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;          // [1:0] action, [3:2] pen, [15:4] colour
    logic        m_axis_tlast;

    // Shadow registers and state of the palette cycler
    rpc_pkg::cfg_t shadow_cfg = rpc_pkg::CFG_RESET;
    logic [2:0]    rr_slot = 3'd0;
    int            band_phase = 0;
    logic [7:0]    pulse_tick = 8'd0;
    logic [3:0]    pulse_level = 4'd0;
    logic          pulse_down = 1'b0;

    rpc_pkg::result_t due_q[$];
    rpc_pkg::result_t arrived_want;
    line_row_t        line_rows[$];
    int               errors = 0;
    int               cycle_count = 0;
    int               burst_left = 1;
    bit               continuous = 1'b0;
    bit               hold_request = 1'b0;

    raster_palette_cycler #(
        .COLOUR_COUNT(COLOUR_COUNT),
        .SLOT_COUNT  (SLOT_COUNT)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // End the run if it hangs
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("raster_palette_cycler_tb: done, errors");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        errors++;
        if (errors <= MAX_PRINTED)
            $display("raster_palette_cycler_tb: %s: got %0h want %0h", what, got, want);
    endtask

    function automatic rpc_pkg::result_t mk_result(input rpc_pkg::action_t act,
                                                   input logic [1:0] pen,
                                                   input logic [11:0] colour,
                                                   input logic last);
        rpc_pkg::result_t r;
        r.action = act;
        r.pen    = pen;
        r.colour = colour;
        r.last   = last;
        return r;
    endfunction

    // Advance the shadow state for one line event and return its palette writes and requests
    function automatic int predict_line_results(input logic [7:0] ln,
                                                output rpc_pkg::result_t r0,
                                                output rpc_pkg::result_t r1);
        int n;
        int band;
        int idx;
        int nl;
        n  = 0;
        r0 = '0;
        r1 = '0;
        if (ln == 8'd0)
        begin
            if (rr_slot == rpc_pkg::SLOT_KEY_SCAN)
            begin
                r0 = mk_result(rpc_pkg::ACT_KEY_SCAN, NO_PEN, NO_COLOUR, 1'b1);
                n  = 1;
            end
            else if (rr_slot == rpc_pkg::SLOT_CLOCK_TICK)
            begin
                r0 = mk_result(rpc_pkg::ACT_CLOCK_TICK, NO_PEN, NO_COLOUR, 1'b1);
                n  = 1;
            end
            else if (rr_slot == rpc_pkg::SLOT_PHASE)
            begin
                band_phase = (band_phase + 1 >= COLOUR_COUNT) ? 0 : band_phase + 1;
            end
            else if (rr_slot == rpc_pkg::SLOT_PULSE)
            begin
                // Step the triangle once the prescaler reaches the speed
                pulse_tick = pulse_tick + 8'd1;
                if (pulse_tick >= shadow_cfg.pulse_speed)
                begin
                    pulse_tick = 8'd0;
                    nl = pulse_down ? ((int'(pulse_level) + 255) & 255) : int'(pulse_level) + 1;
                    if (nl >= int'(shadow_cfg.pulse_max))
                    begin
                        pulse_level = shadow_cfg.pulse_max;
                        pulse_down  = 1'b1;
                    end
                    else
                    begin
                        pulse_level = nl[3:0];
                        if (nl == 0)
                            pulse_down = 1'b0;
                    end
                end
            end
            rr_slot = (int'(rr_slot) + 1 >= SLOT_COUNT) ? 3'd0 : rr_slot + 3'd1;
        end
        else if (ln == shadow_cfg.reset_line)
        begin
            r0 = mk_result(rpc_pkg::ACT_PALETTE, rpc_pkg::PEN_BACKGROUND,
                           rpc_pkg::COL_WHITE, 1'b0);
            r1 = mk_result(rpc_pkg::ACT_PALETTE, rpc_pkg::PEN_STAR,
                           {4'h0, pulse_level, pulse_level}, 1'b1);
            n  = 2;
        end
        else if (ln == shadow_cfg.text_end_line)
        begin
            r0 = mk_result(rpc_pkg::ACT_PALETTE, rpc_pkg::PEN_TEXT, rpc_pkg::COL_BASE, 1'b1);
            n  = 1;
        end
        else if (ln >= shadow_cfg.text_start_line && ln <= shadow_cfg.text_end_line)
        begin
            band = int'(ln - shadow_cfg.text_start_line) >> 2;
            idx  = (band + COLOUR_COUNT - (band_phase % COLOUR_COUNT)) % COLOUR_COUNT;
            r0   = mk_result(rpc_pkg::ACT_PALETTE, rpc_pkg::PEN_TEXT,
                             BAND_ROM[idx*12 +: 12], 1'b1);
            n    = 1;
        end
        return n;
    endfunction

    // Offer one line event, log what it owes on acceptance, then shape the burst
    task automatic offer_line(input logic [7:0] ln, input bit typed, input int tn,
                              input rpc_pkg::result_t t0, input rpc_pkg::result_t t1);
        rpc_pkg::result_t p0;
        rpc_pkg::result_t p1;
        int               n;
        int               gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ln;
        do
            @(posedge clk);
        while (!s_axis_tready);
        n = predict_line_results(ln, p0, p1);
        if (typed)
        begin
            n  = tn;
            p0 = t0;
            p1 = t1;
        end
        if (n > 0)
            due_q.push_back(p0);
        if (n > 1)
            due_q.push_back(p1);
        if (!continuous)
        begin
            burst_left--;
            if (burst_left <= 0)
            begin
                burst_left = $urandom_range(1, 20);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                if (gap > 0)
                begin
                    s_axis_tvalid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
    endtask

    // Stop sending, wait for every owed result, then let the pipeline drain
    task automatic settle();
        int waited;
        waited = 0;
        s_axis_tvalid <= 1'b0;
        while (due_q.size() != 0 && waited < SETTLE_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (due_q.size() != 0)
        begin
            report_mismatch("results never arrived", due_q.size(), 0);
            due_q.delete();
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input rpc_pkg::reg_idx_t idx, input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            rpc_pkg::REG_RESET_LINE:      shadow_cfg.reset_line      = value;
            rpc_pkg::REG_TEXT_START_LINE: shadow_cfg.text_start_line = value;
            rpc_pkg::REG_TEXT_END_LINE:   shadow_cfg.text_end_line   = value;
            rpc_pkg::REG_PULSE_SPEED:     shadow_cfg.pulse_speed     = value;
            rpc_pkg::REG_PULSE_MAX:       shadow_cfg.pulse_max       = value[3:0];
            default:                      ;
        endcase
    endtask

    task automatic apply_settings(input rpc_pkg::cfg_t s);
        write_reg(rpc_pkg::REG_RESET_LINE, s.reset_line);
        write_reg(rpc_pkg::REG_TEXT_START_LINE, s.text_start_line);
        write_reg(rpc_pkg::REG_TEXT_END_LINE, s.text_end_line);
        write_reg(rpc_pkg::REG_PULSE_SPEED, s.pulse_speed);
        write_reg(rpc_pkg::REG_PULSE_MAX, {4'h0, s.pulse_max});
        cfg_valid <= 1'b0;
    endtask

    function automatic void add_row(input logic [7:0] ln, input bit typed, input int count,
                                    input rpc_pkg::result_t first,
                                    input rpc_pkg::result_t second);
        line_row_t r;
        r.line   = ln;
        r.typed  = typed;
        r.count  = count[1:0];
        r.first  = first;
        r.second = second;
        line_rows.push_back(r);
    endfunction

    // Favor lines that do something under the current settings
    function automatic logic [7:0] pick_line();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35)
            return 8'd0;
        if (r < 50)
            return shadow_cfg.reset_line;
        if (r < 58)
            return shadow_cfg.text_end_line;
        if (r < 85 && shadow_cfg.text_start_line <= shadow_cfg.text_end_line)
            return 8'($urandom_range(shadow_cfg.text_start_line, shadow_cfg.text_end_line));
        return 8'($urandom_range(0, 255));
    endfunction

    // Stall the result side on a changing pattern, with one long hold on request
    initial
    begin
        rx_mode_t mode;
        int       seg;
        int       k;
        @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            mode = rx_mode_t'($urandom_range(0, 3));
            seg  = $urandom_range(8, 64);
            for (k = 0; k < seg; k++)
            begin
                case (mode)
                    RX_OPEN:   m_axis_tready <= 1'b1;
                    RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
                    default:   m_axis_tready <= (k % 3 != 2);
                endcase
                @(posedge clk);
            end
        end
    end

    // Check each result transfer against the oldest owed result
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (due_q.size() == 0)
            begin
                report_mismatch("result with none owed", {m_axis_tlast, m_axis_tdata}, 0);
            end
            else
            begin
                arrived_want = due_q.pop_front();
                if (m_axis_tdata[1:0] != arrived_want.action)
                    report_mismatch("action", m_axis_tdata[1:0], arrived_want.action);
                if (m_axis_tdata[3:2] != arrived_want.pen)
                    report_mismatch("pen", m_axis_tdata[3:2], arrived_want.pen);
                if (m_axis_tdata[15:4] != arrived_want.colour)
                    report_mismatch("colour", m_axis_tdata[15:4], arrived_want.colour);
                if (m_axis_tlast != arrived_want.last)
                    report_mismatch("last", m_axis_tlast, arrived_want.last);
            end
        end
    end

    initial
    begin
        rpc_pkg::cfg_t plan [0:6];
        line_row_t     row;
        int            p;
        int            i;
        int            start;

        // Settings per phase: defaults with fast pulse, all zero, all ones, empty window,
        // reset line inside the window, reset line on the end line, then random
        plan[0] = '{8'd8, 8'd120, 8'd148, 8'd1, 4'd15};
        plan[1] = '{8'd0, 8'd0, 8'd0, 8'd0, 4'd0};
        plan[2] = '{8'd255, 8'd255, 8'd255, 8'd255, 4'd15};
        plan[3] = '{8'd200, 8'd100, 8'd40, 8'd2, 4'd7};
        plan[4] = '{8'd50, 8'd40, 8'd140, 8'd0, 4'd3};
        plan[5] = '{8'd60, 8'd10, 8'd60, 8'd1, 4'd9};
        start   = $urandom_range(0, 200);
        plan[6] = '{8'($urandom_range(1, 255)), 8'(start), 8'(start + $urandom_range(0, 55)),
                    8'($urandom_range(0, 3)), 4'($urandom_range(0, 15))};

        // Hold reset, then release on a clock edge
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed events under reset settings
        add_row(8'd8, 1, 2,
                mk_result(rpc_pkg::ACT_PALETTE, rpc_pkg::PEN_BACKGROUND,
                          rpc_pkg::COL_WHITE, 1'b0),
                mk_result(rpc_pkg::ACT_PALETTE, rpc_pkg::PEN_STAR, 12'h000, 1'b1));
        add_row(8'd148, 1, 1,
                mk_result(rpc_pkg::ACT_PALETTE, rpc_pkg::PEN_TEXT, rpc_pkg::COL_BASE, 1'b1),
                '0);
        add_row(8'd120, 1, 1,
                mk_result(rpc_pkg::ACT_PALETTE, rpc_pkg::PEN_TEXT, 12'h0E6, 1'b1), '0);
        add_row(8'd147, 1, 1,
                mk_result(rpc_pkg::ACT_PALETTE, rpc_pkg::PEN_TEXT, 12'h7F0, 1'b1), '0);
        add_row(8'd119, 1, 0, '0, '0);
        add_row(8'd149, 1, 0, '0, '0);
        add_row(8'd255, 1, 0, '0, '0);
        add_row(8'd0, 1, 0, '0, '0);
        add_row(8'd0, 1, 1, mk_result(rpc_pkg::ACT_KEY_SCAN, NO_PEN, NO_COLOUR, 1'b1), '0);
        add_row(8'd0, 1, 1, mk_result(rpc_pkg::ACT_CLOCK_TICK, NO_PEN, NO_COLOUR, 1'b1), '0);
        add_row(8'd0, 0, 0, '0, '0);
        add_row(8'd120, 0, 0, '0, '0);
        add_row(8'd0, 0, 0, '0, '0);
        add_row(8'd0, 0, 0, '0, '0);
        add_row(8'd0, 0, 0, '0, '0);
        add_row(8'd0, 0, 0, '0, '0);
        add_row(8'd136, 0, 0, '0, '0);
        add_row(8'd1, 0, 0, '0, '0);
        add_row(8'd128, 0, 0, '0, '0);
        add_row(8'd8, 0, 0, '0, '0);
        foreach (line_rows[i])
        begin
            row = line_rows[i];
            offer_line(row.line, row.typed, row.count, row.first, row.second);
        end
        settle();

        // Random phases, each under its own settings
        for (p = 0; p < 7; p++)
        begin
            apply_settings(plan[p]);
            if (p == 0)
            begin
                hold_request = 1'b1;
                continuous   = 1'b1;
            end
            for (i = 0; i < PHASE_ITEMS; i++)
            begin
                if (i == 80)
                    continuous = 1'b0;
                offer_line(pick_line(), 0, 0, '0, '0);
            end
            settle();
        end

        if (errors == 0)
            $display("raster_palette_cycler_tb: done, clean");
        else
            $display("raster_palette_cycler_tb: done, errors");
        $finish;
    end

endmodule

// ----- raster_palette_cycler.f -----
+incdir+hw/rtl
hw/rtl/rpc_pkg.sv
hw/rtl/rpc_eval.sv
hw/rtl/raster_palette_cycler.sv
test/raster_palette_cycler_tb.sv
